>>> src/multistream_audio_mixer_top_assert.svh
// Assertion helpers for the mixer top level.
// Both sample on the rising edge of i_clk and stay quiet while i_rst_n is low.
`ifndef MULTISTREAM_AUDIO_MIXER_TOP_ASSERT_SVH
`define MULTISTREAM_AUDIO_MIXER_TOP_ASSERT_SVH

// Property that must hold in the same cycle.
`define MSMIX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property that must hold in the cycle after the trigger.
`define MSMIX_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

>>> src/msmix_pkg.sv
package msmix_pkg;

    localparam int STREAMS    = 4;
    localparam int FIFO_DEPTH = 1024;

    localparam int GAIN_REGS  = 4;
    localparam int GAIN_IDX_W = $clog2(GAIN_REGS);
    localparam int MASK_W     = 4;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 8;
    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = 2 * SAMPLE_W;
    localparam int LEVEL_W    = 11;
    localparam int KIND_W     = 2;
    localparam int SID_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int STREAM_W   = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int ADDR_W     = STREAM_W + PTR_W;
    localparam int MEM_DEPTH  = 2 ** ADDR_W;

    localparam int UNITY_GAIN = 256;
    localparam int S16_MIN    = -32768;
    localparam int S16_MAX    = 32767;

    // signed sample times zero-extended gain, then scaled term and running sum
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 2;
    localparam int SCALE_W    = SAMPLE_W + GAIN_W - GAIN_FRAC;
    localparam int ACC_W      = SCALE_W + STREAM_W + 1;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_PUSH  = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_TICK  = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_FLUSH = KIND_W'(2);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_3 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_MUTE   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE  = CFG_IDX_W'(5);

    typedef enum logic [1:0] {
        OP_REPORT,
        OP_WRITE,
        OP_MIX
    } t_op;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_MUL,
        B_ACC,
        B_DONE
    } t_bstate;

    typedef struct packed {
        t_op                                op;
        logic [ADDR_W-1:0]                  waddr;
        logic [FRAME_W-1:0]                 wdata;
        logic [STREAMS-1:0]                 pop_mask;
        logic [STREAMS-1:0][PTR_W-1:0]      rd_ptr;
        logic                               push_ok;
        logic [LEVEL_W-1:0]                 level;
    } t_cmd;

    typedef struct packed {
        logic                               frame_valid;
        logic signed [SAMPLE_W-1:0]         mix_left;
        logic signed [SAMPLE_W-1:0]         mix_right;
        logic                               push_accepted;
        logic [LEVEL_W-1:0]                 stream_level;
    } t_result;

endpackage

>>> src/msmix_front.sv
module msmix_front (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_push,
    output logic                                        o_full,
    input  logic [msmix_pkg::KIND_W-1:0]                i_kind,
    input  logic [msmix_pkg::SID_W-1:0]                 i_stream_id,
    input  logic signed [msmix_pkg::SAMPLE_W-1:0]       i_sample_left,
    input  logic signed [msmix_pkg::SAMPLE_W-1:0]       i_sample_right,
    input  logic [msmix_pkg::STREAMS-1:0]               i_hold,
    output logic                                        o_q_push,
    output msmix_pkg::t_cmd                             o_q_cmd,
    input  logic                                        i_q_full
);
    import msmix_pkg::*;

    logic [CNT_W-1:0]    r_level [STREAMS];
    logic [CNT_W-1:0]    n_level [STREAMS];
    logic [PTR_W-1:0]    r_rd    [STREAMS];
    logic [PTR_W-1:0]    n_rd    [STREAMS];
    logic [PTR_W-1:0]    r_wr    [STREAMS];
    logic [PTR_W-1:0]    n_wr    [STREAMS];
    logic                present;
    logic [STREAM_W-1:0] sid;
    logic                accept;
    t_cmd                cmd;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        adv = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign present  = (int'(i_stream_id) < STREAMS);
    assign sid      = STREAM_W'(i_stream_id);
    assign accept   = i_push & ~i_q_full;
    assign o_full   = i_q_full;
    assign o_q_push = accept;
    assign o_q_cmd  = cmd;

    // Bookkeeping for the item: pointers and levels settle here, the back end
    // only moves data.
    always_comb begin
        n_level = r_level;
        n_rd    = r_rd;
        n_wr    = r_wr;
        cmd     = '0;
        cmd.op  = OP_REPORT;
        unique case (i_kind)
            KIND_PUSH: begin
                if (present && (r_level[sid] < CNT_W'(FIFO_DEPTH))) begin
                    cmd.op       = OP_WRITE;
                    cmd.waddr    = {sid, r_wr[sid]};
                    cmd.wdata    = {i_sample_right, i_sample_left};
                    cmd.push_ok  = 1'b1;
                    n_wr[sid]    = adv(r_wr[sid]);
                    n_level[sid] = r_level[sid] + 1'b1;
                end
            end
            KIND_TICK: begin
                cmd.op = OP_MIX;
                for (int s = 0; s < STREAMS; s++) begin
                    cmd.rd_ptr[s] = r_rd[s];
                    if (!i_hold[s] && (r_level[s] != '0)) begin
                        cmd.pop_mask[s] = 1'b1;
                        n_rd[s]         = adv(r_rd[s]);
                        n_level[s]      = r_level[s] - 1'b1;
                    end
                end
            end
            KIND_FLUSH: begin
                if (present) begin
                    n_level[sid] = '0;
                    n_rd[sid]    = '0;
                    n_wr[sid]    = '0;
                end
            end
            default: ;
        endcase
        cmd.level = present ? LEVEL_W'(n_level[sid]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STREAMS; s++) begin
                r_level[s] <= '0;
                r_rd[s]    <= '0;
                r_wr[s]    <= '0;
            end
        end else if (accept) begin
            r_level <= n_level;
            r_rd    <= n_rd;
            r_wr    <= n_wr;
        end
    end

endmodule

>>> src/msmix_cmdq.sv
module msmix_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  msmix_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output msmix_pkg::t_cmd o_head,
    output logic            o_empty
);
    import msmix_pkg::*;

    t_cmd                  r_slot [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wptr;
    logic [CMDQ_PTR_W-1:0] r_rptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

>>> src/msmix_back.sv
module msmix_back (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  msmix_pkg::t_cmd                         i_head,
    input  logic                                    i_q_empty,
    output logic                                    o_q_pop,
    input  logic [msmix_pkg::STREAMS-1:0][msmix_pkg::GAIN_W-1:0] i_gain,
    output msmix_pkg::t_result                      o_result,
    output logic                                    o_valid,
    input  logic                                    i_pop
);
    import msmix_pkg::*;

    logic [FRAME_W-1:0]        r_mem [MEM_DEPTH];
    logic [FRAME_W-1:0]        r_rdata;
    t_bstate                   r_state;
    t_bstate                   n_state;
    logic [STREAM_W-1:0]       r_idx;
    logic signed [PROD_W-1:0]  r_prod_l;
    logic signed [PROD_W-1:0]  r_prod_r;
    logic signed [ACC_W-1:0]   r_acc_l;
    logic signed [ACC_W-1:0]   r_acc_r;
    t_result                   r_out;
    logic                      r_out_valid;

    logic                      last;
    logic                      sel;
    logic                      slot_free;
    logic                      mem_we;
    logic                      mem_re;
    logic                      load_out;
    logic [ADDR_W-1:0]         raddr;
    logic signed [SAMPLE_W:0]  mul_a_l;
    logic signed [SAMPLE_W:0]  mul_a_r;
    logic signed [GAIN_W:0]    mul_b;
    t_result                   res;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] x);
        if (x < ACC_W'(S16_MIN)) begin
            sat16 = SAMPLE_W'(S16_MIN);
        end else if (x > ACC_W'(S16_MAX)) begin
            sat16 = SAMPLE_W'(S16_MAX);
        end else begin
            sat16 = SAMPLE_W'(x);
        end
    endfunction

    assign last      = (r_idx == STREAM_W'(STREAMS - 1));
    assign sel       = i_head.pop_mask[r_idx];
    assign slot_free = ~r_out_valid | i_pop;
    assign raddr     = {r_idx, i_head.rd_ptr[r_idx]};
    assign mul_a_l   = {r_rdata[SAMPLE_W-1], r_rdata[SAMPLE_W-1:0]};
    assign mul_a_r   = {r_rdata[FRAME_W-1], r_rdata[FRAME_W-1:SAMPLE_W]};
    assign mul_b     = {1'b0, i_gain[r_idx]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_head.op == OP_MIX) ? B_READ : B_DONE;
                end
            end
            B_READ: begin
                if (sel) begin
                    n_state = B_MUL;
                end else if (last) begin
                    n_state = B_DONE;
                end
            end
            B_MUL:   n_state = B_ACC;
            B_ACC:   n_state = last ? B_DONE : B_READ;
            B_DONE: begin
                if (slot_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        mem_we   = (r_state == B_IDLE) && !i_q_empty && (i_head.op == OP_WRITE);
        mem_re   = (r_state == B_READ) && sel;
        load_out = (r_state == B_DONE) && slot_free;
        o_q_pop  = load_out;
    end

    always_comb begin
        res               = '0;
        res.push_accepted = i_head.push_ok;
        res.stream_level  = i_head.level;
        if (i_head.op == OP_MIX) begin
            res.frame_valid = 1'b1;
            res.mix_left    = sat16(r_acc_l);
            res.mix_right   = sat16(r_acc_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_head.waddr] <= i_head.wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    // Walk the streams; a popped stream costs read, multiply and accumulate.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_idx   <= '0;
                r_acc_l <= '0;
                r_acc_r <= '0;
            end
            B_READ: begin
                if (!sel && !last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            B_MUL: begin
                r_prod_l <= mul_a_l * mul_b;
                r_prod_r <= mul_a_r * mul_b;
            end
            B_ACC: begin
                r_acc_l <= r_acc_l + ACC_W'(r_prod_l >>> GAIN_FRAC);
                r_acc_r <= r_acc_r + ACC_W'(r_prod_r >>> GAIN_FRAC);
                if (!last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            default: ;
        endcase
        if (load_out) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result = r_out;
    assign o_valid  = r_out_valid;

endmodule

>>> src/multistream_audio_mixer_top.sv
// Four-stream stereo mixer with one sample queue of 1024 frames per stream.
// Input channel: push/full. Each transfer carries kind, stream_id and a stereo
// frame. A push appends the frame to the stream's queue (refused when full), a
// flush empties the queue, a tick pops one frame from every stream that is not
// muted, not paused and not empty, and sums the scaled samples.
// Result channel: empty/pop. Exactly one result per input transfer, in order;
// the oldest result sits on the o_ ports while empty is low.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write gains and the mute and
// pause masks; write only while no item is in flight.
// Data path: the front end settles queue levels in the accept cycle and hands the
// item to a four-entry command queue. The back end owns the single-port sample
// memory: push, flush or reserved items pass its idle and done states, a tick
// also walks every stream, with the memory read, multiply and accumulate for each
// popped stream and a single read step for each skipped one. A result is loaded
// into the output register only once that register is free.
// Reset: queues empty, gains at unity, masks clear. Sample memory is not cleared.
// A stalled receiver holds the output register; the command queue then fills
// and full rises, and no item is lost.
`include "multistream_audio_mixer_top_assert.svh"

module multistream_audio_mixer_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic [msmix_pkg::KIND_W-1:0]            i_kind,
    input  logic [msmix_pkg::SID_W-1:0]             i_stream_id,
    input  logic signed [msmix_pkg::SAMPLE_W-1:0]   i_sample_left,
    input  logic signed [msmix_pkg::SAMPLE_W-1:0]   i_sample_right,
    output logic                                    empty,
    input  logic                                    pop,
    output logic                                    o_frame_valid,
    output logic signed [msmix_pkg::SAMPLE_W-1:0]   o_mix_left,
    output logic signed [msmix_pkg::SAMPLE_W-1:0]   o_mix_right,
    output logic                                    o_push_accepted,
    output logic [msmix_pkg::LEVEL_W-1:0]           o_stream_level,
    input  logic                                    i_cfg_we,
    input  logic [msmix_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [msmix_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import msmix_pkg::*;

    logic [GAIN_W-1:0]                 r_gain [GAIN_REGS];
    logic [MASK_W-1:0]                 r_mute;
    logic [MASK_W-1:0]                 r_pause;

    logic [STREAMS-1:0][GAIN_W-1:0]    stream_gain;
    logic [STREAMS-1:0]                stream_hold;

    logic                              q_push;
    logic                              q_full;
    logic                              q_pop;
    logic                              q_empty;
    t_cmd                              q_cmd;
    t_cmd                              q_head;
    t_result                           result;
    logic                              out_valid;

    // Configuration registers; unknown indexes drop the write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < GAIN_REGS; g++) begin
                r_gain[g] <= GAIN_W'(UNITY_GAIN);
            end
            r_mute  <= '0;
            r_pause <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx) inside
                REG_GAIN_0, REG_GAIN_1, REG_GAIN_2, REG_GAIN_3:
                    r_gain[i_cfg_idx[GAIN_IDX_W-1:0]] <= i_cfg_data[GAIN_W-1:0];
                REG_MUTE:  r_mute  <= i_cfg_data[MASK_W-1:0];
                REG_PAUSE: r_pause <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Streams without their own registers run at unity gain and never hold.
    for (genvar s = 0; s < STREAMS; s++) begin : g_stream
        if (s < GAIN_REGS) begin : g_gain
            assign stream_gain[s] = r_gain[s];
        end else begin : g_unity
            assign stream_gain[s] = GAIN_W'(UNITY_GAIN);
        end
        if (s < MASK_W) begin : g_mask
            assign stream_hold[s] = r_mute[s] | r_pause[s];
        end else begin : g_free
            assign stream_hold[s] = 1'b0;
        end
    end

    msmix_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_kind         (i_kind),
        .i_stream_id    (i_stream_id),
        .i_sample_left  (i_sample_left),
        .i_sample_right (i_sample_right),
        .i_hold         (stream_hold),
        .o_q_push       (q_push),
        .o_q_cmd        (q_cmd),
        .i_q_full       (q_full)
    );

    msmix_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    msmix_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_gain    (stream_gain),
        .o_result  (result),
        .o_valid   (out_valid),
        .i_pop     (pop)
    );

    assign empty           = ~out_valid;
    assign o_frame_valid   = result.frame_valid;
    assign o_mix_left      = result.mix_left;
    assign o_mix_right     = result.mix_right;
    assign o_push_accepted = result.push_accepted;
    assign o_stream_level  = result.stream_level;

    // Back end retires a command only when one is waiting.
    `MSMIX_ASSERT(a_pop_needs_cmd, !q_pop || !q_empty, "command queue popped while empty")
    // Retiring a command always leaves a result on the output.
    `MSMIX_ASSERT_NEXT(a_pop_gives_result, q_pop, !empty, "retired command left no result")
    // A tick result never reports a stored push.
    `MSMIX_ASSERT(a_tick_not_push, empty || !o_frame_valid || !o_push_accepted,
        "tick result flagged as accepted push")

endmodule
